// File: rtl/core/hexacode_to_golay_mog_words_unit_assert.svh
// ---------------------------------------------------------------------------
// hexacode to golay mog words: assertion macros
// implication checks clocked on a named clock, disabled while reset is low
// ---------------------------------------------------------------------------
`ifndef HEXACODE_TO_GOLAY_MOG_WORDS_UNIT_ASSERT_SVH
`define HEXACODE_TO_GOLAY_MOG_WORDS_UNIT_ASSERT_SVH

// same-cycle implication
`define HGMW_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HGMW_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/hgmw_pkg.sv
// ---------------------------------------------------------------------------
// hgmw_pkg
// types and the column interpretation table for the hexacode mog unit
// ---------------------------------------------------------------------------
package hgmw_pkg;

	localparam int NUM_COLS = 6;
	localparam int NUM_ROWS = 4;
	localparam logic [5:0] LAST_INDEX = 6'd63;

	typedef logic [1:0] sym_t;
	typedef sym_t [NUM_COLS-1:0] hexword_t;
	typedef logic [3:0] nib_t;

	typedef struct packed {
		logic [23:0] codeword;
		logic [5:0]  rep_index;
		logic        last;
	} result_t;

	// bit r of an entry is mog row r; indexed [symbol][interpretation]
	localparam nib_t COL_PATTERN [4][4] = '{
		'{4'h1, 4'hE, 4'h0, 4'hF},
		'{4'h2, 4'hD, 4'h3, 4'hC},
		'{4'h4, 4'hB, 4'h5, 4'hA},
		'{4'h8, 4'h7, 4'h9, 4'h6}
	};

endpackage

// File: rtl/core/hgmw_interp.sv
// ---------------------------------------------------------------------------
// hgmw_interp
// builds one 4x6 mog array from a hexacode word and an interpretation index
// ---------------------------------------------------------------------------
module hgmw_interp (
	input  hgmw_pkg::hexword_t syms,
	input  logic [5:0]         idx,
	output hgmw_pkg::result_t  res
);
	import hgmw_pkg::*;

	logic       par;
	logic [1:0] sel [NUM_COLS];
	nib_t       nib [NUM_COLS];
	nib_t       nib5_base;
	logic       top;

	always_comb begin
		par = idx[5];
		sel[0] = idx[5:4];
		for (int k = 1; k < 5; k++) begin
			sel[k] = {par, idx[3'(4 - k)]};
		end
		for (int k = 0; k < 5; k++) begin
			nib[k] = COL_PATTERN[syms[k]][sel[k]];
		end
		// top-row parity over the first five columns
		top = nib[0][0] ^ nib[1][0] ^ nib[2][0] ^ nib[3][0] ^ nib[4][0];
		nib5_base = COL_PATTERN[syms[5]][{par, 1'b0}];
		// odd top row for interpretations 0-31 (idx[5] low), even for 32-63
		if ((nib5_base[0] ^ top) != ~par) begin
			sel[5] = {par, 1'b1};
		end else begin
			sel[5] = {par, 1'b0};
		end
		nib[5] = COL_PATTERN[syms[5]][sel[5]];
		for (int r = 0; r < NUM_ROWS; r++) begin
			for (int c = 0; c < NUM_COLS; c++) begin
				res.codeword[r * NUM_COLS + c] = nib[c][r];
			end
		end
		res.rep_index = idx;
		res.last = (idx == LAST_INDEX);
	end

endmodule

// File: rtl/core/hexacode_to_golay_mog_words_unit.sv
// ---------------------------------------------------------------------------
// hexacode_to_golay_mog_words_unit
// expands one hexacode word into its 64 golay mog interpretations
// ---------------------------------------------------------------------------
// usage
//   slave beat: one hexacode word, six 2-bit gf(4) symbols in s_tdata
//   master beats: 64 per word, one mog array each with its interpretation
//   number; m_tlast marks the beat with interpretation 63
// first array: the accepted word is held in the word register, and the index
//   counter then steers its first array into the output register
// throughput: one array per cycle while m_tready does not stall, set by the
//   single word register and the index counter feeding the output register
// the next word is taken in the same cycle the last array of the current
//   word enters the output register, so words follow without a gap
// a stall on m_tready holds the output register and the counter; the slave
//   side then stays not ready until the current word is fully issued
// reset clears the busy flag and the output valid; no word is in flight
// the hexacode membership of the input is not checked
// ---------------------------------------------------------------------------
module hexacode_to_golay_mog_words_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // sym0, sym1, sym2, sym3, sym4, sym5, 4'b0
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // codeword[23:0], rep_index[5:0], 2'b0
	output logic        m_tlast
);
	import hgmw_pkg::*;

	// word register and interpretation counter
	hexword_t   syms_q;
	logic       busy_q;
	logic [5:0] idx_q;

	// output register
	logic       out_valid_q;
	result_t    out_q;

	result_t    res;
	logic       adv;
	logic       s_acc;
	logic       at_last;

	hgmw_interp u_interp (
		.syms (syms_q),
		.idx  (idx_q),
		.res  (res)
	);

	// move one array into the output register when it is empty or draining
	assign adv     = busy_q && (!out_valid_q || m_tready);
	assign at_last = (idx_q == LAST_INDEX);
	assign s_tready = !busy_q || (adv && at_last);
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (s_acc) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (adv) begin
				idx_q <= idx_q + 6'd1;
				if (at_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// payload of the word register, no reset needed
	always_ff @(posedge clk) begin
		if (s_acc) begin
			syms_q <= s_tdata[11:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q.rep_index, out_q.codeword};
	assign m_tlast  = out_q.last;

	`include "hexacode_to_golay_mog_words_unit_assert.svh"

	`HGMW_ASSERT_IMP(a_last_idx, clk, arst_n, m_tvalid && m_tlast, m_tdata[29:24] == LAST_INDEX, "tlast without index 63")
	`HGMW_ASSERT_NXT(a_acc_start, clk, arst_n, s_acc, busy_q && idx_q == 6'd0, "accepted word did not start at index 0")
	`HGMW_ASSERT_NXT(a_idx_step, clk, arst_n, adv && !at_last, busy_q && idx_q == $past(idx_q) + 6'd1, "index did not step")
	`HGMW_ASSERT_NXT(a_stall_hold, clk, arst_n, busy_q && out_valid_q && !m_tready, idx_q == $past(idx_q), "index moved during stall")

endmodule
